// File: rtl/core/seven_segment_dashboard_driver_defines.svh
// assertion macros shared by the dashboard driver rtl
`ifndef SEVEN_SEGMENT_DASHBOARD_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_DASHBOARD_DRIVER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SSDD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, off while reset is held
`define SSDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/ssdd_pkg.sv
// shared types, constants and digit table for the dashboard driver
package ssdd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int NUM_WORDS   = 5;
    localparam int WORD_W      = 7;
    localparam int WIDX_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 3;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);

    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY    = 8'h80;
    localparam logic [7:0] CMD_MODE       = 8'h01;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SETUP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic                       cmd;
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_ADDR,
        PH_DATA
    } t_phase;

    function automatic t_word seg_code(input logic [3:0] digit);
        t_word code;
        unique case (digit)
            4'd0:    code = 7'h7E;
            4'd1:    code = 7'h30;
            4'd2:    code = 7'h6D;
            4'd3:    code = 7'h79;
            4'd4:    code = 7'h33;
            4'd5:    code = 7'h5B;
            4'd6:    code = 7'h5F;
            4'd7:    code = 7'h70;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h7B;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/ssdd_front.sv
// front end: takes update and setup beats, splits speed into digits, builds display words
module ssdd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_cmd,
    input  logic [9:0]            i_speed_tenths,
    input  logic [2:0]            i_battery_level,
    input  logic                  i_unit_kmh,
    input  logic                  i_unit_mph,
    input  logic                  i_bluetooth_mark,
    input  logic                  i_turn_left,
    input  logic                  i_turn_right,
    input  logic                  i_light_mark,
    input  logic                  i_reserved_mark,
    input  logic                  i_maint_red,
    input  logic                  i_maint_green,
    input  ssdd_pkg::t_q_stat     i_q_stat,
    output logic                  o_q_push,
    output ssdd_pkg::t_job        o_q_job
);

    logic        r_s1_vld;
    logic        r_s1_cmd;
    logic [9:0]  r_s1_speed;
    logic [6:0]  r_s1_q10;
    logic [3:0]  r_s1_q100;
    logic [2:0]  r_s1_level;
    logic [8:0]  r_s1_flags;

    logic        w_s1_rdy;
    logic        w_take;
    logic [17:0] w_prod10;
    logic [15:0] w_prod100;
    logic [9:0]  w_rem0;
    logic [6:0]  w_rem1;
    logic [3:0]  w_d0;
    logic [3:0]  w_d1;
    logic [3:0]  w_d2;
    ssdd_pkg::t_word w_word0;
    ssdd_pkg::t_word w_word1;

    assign w_s1_rdy = !r_s1_vld || !i_q_stat.full;
    assign o_full   = !w_s1_rdy;
    assign w_take   = i_push && w_s1_rdy;

    // quotients by 10 and 100 through reciprocal multiplies, exact below 1029
    assign w_prod10  = 18'(i_speed_tenths) * 18'd205;
    assign w_prod100 = 16'(i_speed_tenths) * 16'd41;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_vld <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_cmd   <= i_cmd;
            r_s1_speed <= i_speed_tenths;
            r_s1_q10   <= w_prod10[17:11];
            r_s1_q100  <= w_prod100[15:12];
            r_s1_level <= i_battery_level;
            r_s1_flags <= {i_maint_green, i_maint_red, i_reserved_mark, i_unit_kmh,
                           i_unit_mph, i_turn_right, i_light_mark, i_bluetooth_mark,
                           i_turn_left};
        end
    end

    assign w_rem0 = r_s1_speed - ({r_s1_q10, 3'b000} + {2'b00, r_s1_q10, 1'b0});
    assign w_rem1 = r_s1_q10 - 7'({r_s1_q100, 3'b000} + {2'b00, r_s1_q100, 1'b0});
    assign w_d0   = w_rem0[3:0];
    assign w_d1   = w_rem1[3:0];
    assign w_d2   = (r_s1_q100 >= 4'd10) ? (r_s1_q100 - 4'd10) : r_s1_q100;

    // flags: green, red, reserved, kmh, mph, right, light, bluetooth, left
    assign w_word0 = {r_s1_level >= 3'd1, r_s1_level >= 3'd2, r_s1_level >= 3'd3,
                      r_s1_level >= 3'd4, r_s1_flags[6], r_s1_flags[7], r_s1_flags[8]};
    assign w_word1 = {r_s1_flags[0], r_s1_flags[1], r_s1_flags[2], r_s1_flags[3],
                      1'b1, r_s1_flags[4], r_s1_flags[5]};

    assign o_q_push       = r_s1_vld && !i_q_stat.full;
    assign o_q_job.cmd    = r_s1_cmd;
    assign o_q_job.words  = {ssdd_pkg::seg_code(w_d2), ssdd_pkg::seg_code(w_d1),
                             ssdd_pkg::seg_code(w_d0), w_word1, w_word0};

endmodule

// File: rtl/core/ssdd_queue.sv
// short job queue between front and back
module ssdd_queue #(
    parameter int Depth = ssdd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ssdd_pkg::t_job     i_job,
    input  logic               i_pop,
    output ssdd_pkg::t_job     o_job,
    output ssdd_pkg::t_q_stat  o_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    ssdd_pkg::t_job r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            w_wr;
    logic            w_rd;

    assign o_stat.full  = (r_count == CntFull);
    assign o_stat.empty = (r_count == '0);
    assign w_wr = i_push && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;
    assign o_job = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/ssdd_back.sv
// back end: walks the frames of the head job into the output byte register
module ssdd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdd_pkg::t_job     i_job,
    input  ssdd_pkg::t_q_stat  i_q_stat,
    output logic               o_q_pop,
    input  logic [7:0]         i_ctl_byte,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_serial_byte,
    output logic               o_strobe_begin,
    output logic               o_strobe_end,
    output logic               o_last_byte
);

    ssdd_pkg::t_phase r_phase;
    ssdd_pkg::t_phase n_phase;
    logic [ssdd_pkg::WIDX_W-1:0] r_word;
    logic [ssdd_pkg::WIDX_W-1:0] n_word;

    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_sb;
    logic       r_out_se;
    logic       r_out_last;

    logic       w_out_rdy;
    logic       w_go;
    logic [7:0] w_byte;
    logic       w_sb;
    logic       w_se;
    logic       w_last;

    assign w_out_rdy = !r_out_vld || i_pop;
    assign w_go      = !i_q_stat.empty && w_out_rdy;
    assign o_q_pop   = w_go && w_last;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_word  = r_word;
        if (w_go) begin
            if (i_job.cmd == ssdd_pkg::CMD_SETUP) begin
                n_phase = (r_phase == ssdd_pkg::PH_CMD) ? ssdd_pkg::PH_ADDR
                                                        : ssdd_pkg::PH_CMD;
            end else begin
                unique case (r_phase)
                    ssdd_pkg::PH_CMD:  n_phase = ssdd_pkg::PH_ADDR;
                    ssdd_pkg::PH_ADDR: n_phase = ssdd_pkg::PH_DATA;
                    ssdd_pkg::PH_DATA: begin
                        n_phase = ssdd_pkg::PH_CMD;
                        n_word  = w_last ? '0 : r_word + 1'b1;
                    end
                    default:           n_phase = ssdd_pkg::PH_CMD;
                endcase
            end
        end
    end

    // beat contents
    always_comb begin
        w_byte = ssdd_pkg::CMD_DATA_FIXED;
        w_sb   = 1'b1;
        w_se   = 1'b1;
        w_last = 1'b0;
        if (i_job.cmd == ssdd_pkg::CMD_SETUP) begin
            if (r_phase == ssdd_pkg::PH_CMD) begin
                w_byte = ssdd_pkg::CMD_MODE;
            end else begin
                w_byte = i_ctl_byte;
                w_last = 1'b1;
            end
        end else begin
            unique case (r_phase)
                ssdd_pkg::PH_CMD: begin
                    w_byte = ssdd_pkg::CMD_DATA_FIXED;
                end
                ssdd_pkg::PH_ADDR: begin
                    w_byte = ssdd_pkg::CMD_ADDRESS | {4'b0000, r_word, 1'b0};
                    w_se   = 1'b0;
                end
                ssdd_pkg::PH_DATA: begin
                    w_byte = {1'b0, i_job.words[r_word]};
                    w_sb   = 1'b0;
                    w_last = (r_word == ssdd_pkg::LAST_WORD);
                end
                default: begin
                    w_byte = ssdd_pkg::CMD_DATA_FIXED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ssdd_pkg::PH_CMD;
            r_word    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_word  <= n_word;
            if (w_out_rdy) begin
                r_out_vld <= w_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_byte <= w_byte;
            r_out_sb   <= w_sb;
            r_out_se   <= w_se;
            r_out_last <= w_last;
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_serial_byte  = r_out_byte;
    assign o_strobe_begin = r_out_sb;
    assign o_strobe_end   = r_out_se;
    assign o_last_byte    = r_out_last;

endmodule

// File: rtl/core/seven_segment_dashboard_driver.sv
// path: item -> front stage register -> job queue -> output byte register
// bytes: an update gives 15 bytes, a setup 2 bytes,
//   one byte per cycle out of the single output byte register while a job waits and pop allows
// reset: synchronous, active low; empties front stage, queue and output register,
//   brightness back to 7 and display on
// top level of the dashboard driver: front, job queue, back and control registers
`include "seven_segment_dashboard_driver_defines.svh"

module seven_segment_dashboard_driver #(
    parameter int QueueDepth = ssdd_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssdd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssdd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_cmd,
    input  logic [9:0]                      i_speed_tenths,
    input  logic [2:0]                      i_battery_level,
    input  logic                            i_unit_kmh,
    input  logic                            i_unit_mph,
    input  logic                            i_bluetooth_mark,
    input  logic                            i_turn_left,
    input  logic                            i_turn_right,
    input  logic                            i_light_mark,
    input  logic                            i_reserved_mark,
    input  logic                            i_maint_red,
    input  logic                            i_maint_green,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_serial_byte,
    output logic                            o_strobe_begin,
    output logic                            o_strobe_end,
    output logic                            o_last_byte
);

    logic [2:0]        r_brightness;
    logic              r_display_en;
    logic [7:0]        w_ctl_byte;

    logic              w_q_push;
    logic              w_q_pop;
    ssdd_pkg::t_job    w_push_job;
    ssdd_pkg::t_job    w_head_job;
    ssdd_pkg::t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= 3'd7;
            r_display_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssdd_pkg::CFG_BRIGHTNESS: r_brightness <= i_cfg_data[2:0];
                ssdd_pkg::CFG_ENABLE:     r_display_en <= i_cfg_data[0];
                default:                  r_brightness <= r_brightness;
            endcase
        end
    end

    assign w_ctl_byte = ssdd_pkg::CMD_DISPLAY | {4'b0000, r_display_en, r_brightness};

    ssdd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_speed_tenths   (i_speed_tenths),
        .i_battery_level  (i_battery_level),
        .i_unit_kmh       (i_unit_kmh),
        .i_unit_mph       (i_unit_mph),
        .i_bluetooth_mark (i_bluetooth_mark),
        .i_turn_left      (i_turn_left),
        .i_turn_right     (i_turn_right),
        .i_light_mark     (i_light_mark),
        .i_reserved_mark  (i_reserved_mark),
        .i_maint_red      (i_maint_red),
        .i_maint_green    (i_maint_green),
        .i_q_stat         (w_q_stat),
        .o_q_push         (w_q_push),
        .o_q_job          (w_push_job)
    );

    ssdd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    ssdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_head_job),
        .i_q_stat       (w_q_stat),
        .o_q_pop        (w_q_pop),
        .i_ctl_byte     (w_ctl_byte),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_serial_byte  (o_serial_byte),
        .o_strobe_begin (o_strobe_begin),
        .o_strobe_end   (o_strobe_end),
        .o_last_byte    (o_last_byte)
    );

    // every beat belongs to an open or closing frame
    `SSDD_ASSERT_IMPLY(a_frame_edge, i_clk, i_rst_n, !empty, o_strobe_begin || o_strobe_end)
    // final beat of an item closes its frame
    `SSDD_ASSERT_IMPLY(a_last_closes, i_clk, i_rst_n, !empty && o_last_byte, o_strobe_end)
    // front stalls only behind a full queue
    `SSDD_ASSERT_IMPLY(a_full_cause, i_clk, i_rst_n, full, w_q_stat.full && !w_q_stat.empty)
    // brightness write lands in the control byte
    `SSDD_ASSERT_NEXT(a_cfg_bright, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_idx == ssdd_pkg::CFG_BRIGHTNESS),
        w_ctl_byte[2:0] == $past(i_cfg_data[2:0]))

endmodule
